// File: src/kgd_pkg.sv
package kgd_pkg;

    // Number of keys handled by the detector
    localparam int NUM_KEYS = 4;
    // Keys that have a pin in the level and trigger words
    localparam int KEY_PINS = 4;

    localparam int FLAG_W  = 7;
    localparam int TIME_W  = 16;
    localparam int SCAN_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Event flag bits
    localparam logic [FLAG_W-1:0] FLG_PRESSING = 7'h01;
    localparam logic [FLAG_W-1:0] FLG_DOWN     = 7'h02;
    localparam logic [FLAG_W-1:0] FLG_UP       = 7'h04;
    localparam logic [FLAG_W-1:0] FLG_CLICK    = 7'h08;
    localparam logic [FLAG_W-1:0] FLG_DOUBLE   = 7'h10;
    localparam logic [FLAG_W-1:0] FLG_LONG     = 7'h20;
    localparam logic [FLAG_W-1:0] FLG_REPEAT   = 7'h40;

    // Input item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_GAP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT         = 3'd5;

    // Gesture machine states
    typedef enum logic [2:0] {
        GS_FREE     = 3'd0,
        GS_HELD     = 3'd1,
        GS_RELEASED = 3'd2,
        GS_LONG     = 3'd3,
        GS_SECOND   = 3'd4
    } gesture_state_t;

    // Timing settings shared by every key cell
    typedef struct packed {
        logic [TIME_W-1:0] long_press_time;
        logic [TIME_W-1:0] double_click_gap;
        logic [TIME_W-1:0] double_click_timeout;
        logic [TIME_W-1:0] repeat_time;
    } key_timing_t;

    // Per-key control from the item stage
    typedef struct packed {
        logic              tick_en;
        logic              sample_en;
        logic              pressed;
        logic              check_en;
        logic [FLAG_W-1:0] mask;
    } key_ctrl_t;

endpackage

// File: src/kgd_if.sv
interface kgd_in_if;
    import kgd_pkg::*;

    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] key_levels;
    logic [1:0] key_id;
    logic [FLAG_W-1:0] event_mask;

    modport source (output valid, output mode, output key_levels, output key_id,
                    output event_mask, input ready);
    modport sink (input valid, input mode, input key_levels, input key_id,
                  input event_mask, output ready);
endinterface

interface kgd_out_if;
    import kgd_pkg::*;

    logic       valid;
    logic       ready;
    logic       event_hit;
    logic [FLAG_W-1:0] flag_bits;

    modport source (output valid, output event_hit, output flag_bits, input ready);
    modport sink (input valid, input event_hit, input flag_bits, output ready);
endinterface

// File: src/kgd_key.sv
module kgd_key
    import kgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_ctrl_t         ctrl,
    input  key_timing_t       timing,
    output logic [FLAG_W-1:0] flags
);

    logic                 pressed_reg, pressed_next;
    gesture_state_t       state_reg, state_next;
    logic [TIME_W-1:0]    timer_reg, timer_next;
    logic [FLAG_W-1:0]    flags_reg, flags_next;
    logic [TIME_W-1:0]    timer_dec;
    logic [FLAG_W-1:0]    f;

    assign flags = flags_reg;

    // Count the timer down toward zero on each tick
    assign timer_dec = (timer_reg != '0) ? timer_reg - TIME_W'(1) : timer_reg;

    // Step the gesture machine and the sticky flags
    always_comb
    begin
        pressed_next = pressed_reg;
        state_next   = state_reg;
        timer_next   = timer_reg;
        flags_next   = flags_reg;
        f            = flags_reg;

        if (ctrl.tick_en)
        begin
            timer_next = timer_dec;
            if (ctrl.sample_en)
            begin
                pressed_next = ctrl.pressed;
                if (ctrl.pressed)
                    f = f | FLG_PRESSING;
                else
                    f = f & ~FLG_PRESSING;
                if (!pressed_reg && ctrl.pressed)
                    f = f | FLG_DOWN;
                else if (pressed_reg && !ctrl.pressed)
                    f = f | FLG_UP;

                case (state_reg)
                    GS_HELD:
                    begin
                        if (!ctrl.pressed)
                        begin
                            timer_next = timing.double_click_gap;
                            state_next = GS_RELEASED;
                        end
                        else if (timer_dec == '0)
                        begin
                            timer_next = timing.repeat_time;
                            f          = f | FLG_LONG;
                            state_next = GS_LONG;
                        end
                    end
                    GS_RELEASED:
                    begin
                        if (ctrl.pressed)
                        begin
                            timer_next = timing.double_click_timeout;
                            state_next = GS_SECOND;
                        end
                        else if (timer_dec == '0)
                        begin
                            f          = f | FLG_CLICK;
                            state_next = GS_FREE;
                        end
                    end
                    GS_LONG:
                    begin
                        if (!ctrl.pressed)
                            state_next = GS_FREE;
                        else if (timer_dec == '0)
                        begin
                            f          = f | FLG_REPEAT;
                            timer_next = timing.repeat_time;
                        end
                    end
                    GS_SECOND:
                    begin
                        if (!ctrl.pressed)
                        begin
                            f          = f | FLG_DOUBLE;
                            state_next = GS_FREE;
                        end
                        else if (timer_dec == '0)
                            state_next = GS_LONG;
                    end
                    default:
                    begin
                        if (ctrl.pressed)
                        begin
                            timer_next = timing.long_press_time;
                            state_next = GS_HELD;
                        end
                        else
                            state_next = GS_FREE;
                    end
                endcase
                flags_next = f;
            end
        end
        else if (ctrl.check_en)
        begin
            // Drop matched flags, but leave a pure pressing query alone
            if (((flags_reg & ctrl.mask) != '0) && (ctrl.mask != FLG_PRESSING))
                flags_next = flags_reg & ~ctrl.mask;
        end
    end

    // Hold key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            state_reg   <= GS_FREE;
            timer_reg   <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            pressed_reg <= pressed_next;
            state_reg   <= state_next;
            timer_reg   <= timer_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

// File: src/key_gesture_detector_unit.sv
// Key gesture detector: click, double click, long press and repeat per key.
// Each item is held in the input stage register, then in the result register that
// offers it on the output. Throughput: one item per cycle while the output is not
// stalled; on a tick every key cell updates in the same cycle.
// Reset (rst_n, async low): timers, flags and gesture states clear, registers
// return to their defaults, pipeline empties.
module key_gesture_detector_unit
    import kgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    kgd_in_if.sink                in_ch,
    kgd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [KEY_PINS-1:0] trigger_reg;
    logic [SCAN_W-1:0]   scan_period_reg;
    key_timing_t         timing_reg;
    logic [SCAN_W-1:0]   tick_count_reg, tick_count_next;
    logic [SCAN_W-1:0]   tick_inc;

    logic                s1_valid_reg;
    logic                s1_mode_reg;
    logic [3:0]          s1_levels_reg;
    logic [1:0]          s1_id_reg;
    logic [FLAG_W-1:0]   s1_mask_reg;
    logic                s1_advance;
    logic                do_tick;
    logic                do_sample;

    logic                out_valid_reg;
    logic                out_hit_reg, out_hit_next;
    logic [FLAG_W-1:0]   out_flags_reg, out_flags_next;

    logic [FLAG_W-1:0]   cell_flags_w [NUM_KEYS];
    key_ctrl_t           key_ctrl_w  [NUM_KEYS];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg                     <= 4'd12;
            scan_period_reg                 <= 8'd10;
            timing_reg.long_press_time      <= 16'd100;
            timing_reg.double_click_gap     <= 16'd30;
            timing_reg.double_click_timeout <= 16'd50;
            timing_reg.repeat_time          <= 16'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIGGER_LEVELS: trigger_reg <= cfg_data[KEY_PINS-1:0];
                REG_SCAN_PERIOD:    scan_period_reg <= cfg_data[SCAN_W-1:0];
                REG_LONG_PRESS:     timing_reg.long_press_time <= cfg_data;
                REG_DBL_GAP:        timing_reg.double_click_gap <= cfg_data;
                REG_DBL_TIMEOUT:    timing_reg.double_click_timeout <= cfg_data;
                REG_REPEAT:         timing_reg.repeat_time <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input stage: take a transfer when empty or moving on
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_mode_reg   <= in_ch.mode;
            s1_levels_reg <= in_ch.key_levels;
            s1_id_reg     <= in_ch.key_id;
            s1_mask_reg   <= in_ch.event_mask;
        end
    end

    // Tick counter and sampling strobe
    assign do_tick   = s1_advance && (s1_mode_reg == MODE_TICK);
    assign tick_inc  = tick_count_reg + SCAN_W'(1);
    assign do_sample = (tick_inc >= scan_period_reg);
    assign tick_count_next = do_sample ? '0 : tick_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_count_reg <= '0;
        else if (do_tick)
            tick_count_reg <= tick_count_next;
    end

    // Key cells
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic pressed_w;

        if (k < KEY_PINS)
        begin : g_pin
            assign pressed_w = (s1_levels_reg[k] == trigger_reg[k]);
        end
        else
        begin : g_nopin
            // No pin: the key counts as pressed
            assign pressed_w = 1'b1;
        end

        assign key_ctrl_w[k].tick_en   = do_tick;
        assign key_ctrl_w[k].sample_en = do_sample;
        assign key_ctrl_w[k].pressed   = pressed_w;
        assign key_ctrl_w[k].check_en  = s1_advance && (s1_mode_reg == MODE_CHECK)
                                         && (32'(s1_id_reg) == k);
        assign key_ctrl_w[k].mask      = s1_mask_reg;

        kgd_key u_key (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (key_ctrl_w[k]),
            .timing (timing_reg),
            .flags  (cell_flags_w[k])
        );
    end

    // Select the checked key's flags and form the hit
    always_comb
    begin
        out_flags_next = '0;
        out_hit_next   = 1'b0;
        if (s1_mode_reg == MODE_CHECK)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (32'(s1_id_reg) == k)
                    out_flags_next = cell_flags_w[k];
            end
            out_hit_next = ((out_flags_next & s1_mask_reg) != '0);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_hit_reg   <= out_hit_next;
            out_flags_reg <= out_flags_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_hit = out_hit_reg;
    assign out_ch.flag_bits = out_flags_reg;

endmodule

// File: src/kgd_checker.sv
module kgd_checker
    import kgd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_hit,
    input logic [FLAG_W-1:0] out_flags
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_flags))
        else $error("stalled result changed or dropped");

    // A hit needs a set flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_hit |-> out_flags != '0)
        else $error("hit reported with no flags");

    // Every transfer in is followed by a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("result missing after input transfer");

    // With the output empty the input side is never blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind key_gesture_detector_unit kgd_checker u_kgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hit   (out_ch.event_hit),
    .out_flags (out_ch.flag_bits)
);
